[rtl/fbh_pkg.sv]
// shared constants, codes and controller/datapath interface types for the histogram block
`default_nettype none
package fbh_pkg;

  localparam int NUM_BINS   = 64;
  localparam int COUNT_BITS = 24;
  localparam int BIN_IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // field widths
  localparam int SAMPLE_W   = 32;
  localparam int WIDTH_W    = 31;
  localparam int NBINS_W    = 7;
  localparam int OUT_NUM_W  = 6;
  localparam int OUT_CNT_W  = 24;
  localparam int OUT_DATA_W = 32;

  // divider
  localparam int DIV_STEPS  = SAMPLE_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LOW   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BIN_WIDTH   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BINS_IN_USE = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_LOOK = 6'b000100,
    S_UPD  = 6'b001000,
    S_ORD  = 6'b010000,
    S_OLD  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;     // take input item, start division
    logic div_en;   // one quotient bit
    logic look;     // read counter of the selected bin
    logic upd;      // write back incremented counter
    logic oread;    // read counter for readout
    logic oload;    // load output register, advance readout index
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_item;
    logic out_free;
    logic k_final;
  } sts_t;

endpackage
`default_nettype wire

[rtl/fbh_ctrl.sv]
// controller state machine for the histogram block
`default_nettype none
module fbh_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire fbh_pkg::sts_t sts,
  output fbh_pkg::cmd_t     cmd
);

  fbh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbh_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == fbh_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      fbh_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = fbh_pkg::S_DIV;
        end
      end
      fbh_pkg::S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_done) begin
          state_nxt = fbh_pkg::S_LOOK;
        end
      end
      fbh_pkg::S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = fbh_pkg::S_UPD;
      end
      fbh_pkg::S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last_item ? fbh_pkg::S_ORD : fbh_pkg::S_IDLE;
      end
      fbh_pkg::S_ORD: begin
        cmd.oread = 1'b1;
        state_nxt = fbh_pkg::S_OLD;
      end
      fbh_pkg::S_OLD: begin
        if (sts.out_free) begin
          cmd.oload = 1'b1;
          state_nxt = sts.k_final ? fbh_pkg::S_IDLE : fbh_pkg::S_ORD;
        end
      end
      default: begin
        state_nxt = fbh_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/fbh_dp.sv]
// datapath: config registers, radix-2 divider, bin counter memory, output register
`default_nettype none
module fbh_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [fbh_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [fbh_pkg::SAMPLE_W-1:0]       cfg_wdata,
  input  wire logic [fbh_pkg::SAMPLE_W-1:0]       in_tdata,
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [fbh_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                    out_tlast,
  input  wire fbh_pkg::cmd_t                      cmd,
  output fbh_pkg::sts_t                           sts
);

  localparam int IW = fbh_pkg::BIN_IDX_W;
  localparam int CW = fbh_pkg::COUNT_BITS;
  localparam int SW = fbh_pkg::SAMPLE_W;
  localparam int WW = fbh_pkg::WIDTH_W;
  localparam int NW = fbh_pkg::NBINS_W;

  // configuration
  logic [SW-1:0] range_low_r;
  logic [WW-1:0] bin_width_r;
  logic [NW-1:0] bins_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= '0;
      bin_width_r   <= WW'(65536);
      bins_in_use_r <= NW'(fbh_pkg::NUM_BINS);
    end else if (cfg_we) begin
      case (cfg_addr)
        fbh_pkg::REG_RANGE_LOW:   range_low_r   <= cfg_wdata;
        fbh_pkg::REG_BIN_WIDTH:   bin_width_r   <= cfg_wdata[WW-1:0];
        fbh_pkg::REG_BINS_IN_USE: bins_in_use_r <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // bins in use, clamped to 1..NUM_BINS
  logic [NW-1:0] n_act;
  logic [IW-1:0] top_bin;
  always_comb begin
    if (bins_in_use_r == '0) begin
      n_act = NW'(1);
    end else if (bins_in_use_r > NW'(fbh_pkg::NUM_BINS)) begin
      n_act = NW'(fbh_pkg::NUM_BINS);
    end else begin
      n_act = bins_in_use_r;
    end
  end
  assign top_bin = IW'(n_act - NW'(1));

  // divider: dividend shifts out the top, quotient shifts in the bottom
  logic [SW:0]                 diff;
  logic                        neg_r;
  logic                        last_r;
  logic [SW-1:0]               dvd_r;
  logic [WW-1:0]               rem_r;
  logic [fbh_pkg::STEP_W-1:0]  step_r;
  logic [SW-1:0]               rem_sh;
  logic [SW:0]                 rem_sub;

  assign diff    = {in_tdata[SW-1], in_tdata} - {range_low_r[SW-1], range_low_r};
  assign rem_sh  = {rem_r, dvd_r[SW-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, bin_width_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= diff[SW];
      dvd_r  <= diff[SW-1:0];
      rem_r  <= '0;
      step_r <= '0;
      last_r <= in_tlast;
    end else if (cmd.div_en) begin
      step_r <= step_r + 1'b1;
      if (!rem_sub[SW]) begin
        rem_r <= rem_sub[WW-1:0];
        dvd_r <= {dvd_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WW-1:0];
        dvd_r <= {dvd_r[SW-2:0], 1'b0};
      end
    end
  end

  assign sts.div_done  = (step_r == fbh_pkg::STEP_W'(fbh_pkg::DIV_STEPS - 1));
  assign sts.last_item = last_r;

  // bin selection with clamping
  logic [IW-1:0] bin_sel;
  always_comb begin
    if (neg_r) begin
      bin_sel = '0;
    end else if (bin_width_r == '0 || dvd_r >= SW'(n_act)) begin
      bin_sel = top_bin;
    end else begin
      bin_sel = dvd_r[IW-1:0];
    end
  end

  // counter memory with per-entry valid bits standing in for the clear
  logic [CW-1:0]       mem [fbh_pkg::NUM_BINS];
  logic [fbh_pkg::NUM_BINS-1:0] vld_r;
  logic [IW-1:0]       bin_r;
  logic [IW-1:0]       k_r;
  logic [IW-1:0]       raddr;
  logic [CW-1:0]       rd_r;
  logic                vrd_r;
  logic [CW-1:0]       cur_cnt;
  logic [CW-1:0]       inc_cnt;

  assign raddr   = cmd.look ? bin_sel : k_r;
  assign cur_cnt = vrd_r ? rd_r : '0;
  assign inc_cnt = (cur_cnt == fbh_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign sts.k_final = (k_r == top_bin);

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem[bin_r] <= inc_cnt;
    end
    if (cmd.look || cmd.oread) begin
      rd_r  <= mem[raddr];
      vrd_r <= vld_r[raddr];
    end
    if (cmd.look) begin
      bin_r <= bin_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.upd) begin
      vld_r[bin_r] <= 1'b1;
    end else if (cmd.oload && sts.k_final) begin
      vld_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.load) begin
      k_r <= '0;
    end else if (cmd.oload) begin
      k_r <= k_r + 1'b1;
    end
  end

  // output register
  logic                          out_valid_r;
  logic [fbh_pkg::OUT_NUM_W-1:0] out_num_r;
  logic [fbh_pkg::OUT_CNT_W-1:0] out_cnt_r;
  logic                          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.oload) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.oload) begin
      out_num_r  <= fbh_pkg::OUT_NUM_W'(k_r);
      out_cnt_r  <= fbh_pkg::OUT_CNT_W'(cur_cnt);
      out_last_r <= sts.k_final;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tlast    = out_last_r;
  assign out_tdata    = {{(fbh_pkg::OUT_DATA_W - fbh_pkg::OUT_NUM_W - fbh_pkg::OUT_CNT_W){1'b0}},
                         out_cnt_r, out_num_r};

endmodule
`default_nettype wire

[rtl/fixed_bin_histogram.sv]
// top level of the fixed-bin histogram: controller plus datapath
// each sample item goes through an accept state, the radix-2 divider (one quotient bit per cycle),
// a counter read and a write before the next item is accepted. a last-marked item then reads out
// the bins in use, each by a memory read and an output register load that waits for a free
// output; the final bin's item may wait in the output register while a new item
// is taken. synchronous active-low reset clears all bin counts at once through valid bits,
// restores range_low 0, bin_width 1.0 and 64 bins in use; no clearing pass is needed.
`default_nettype none
module fixed_bin_histogram (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [fbh_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [fbh_pkg::SAMPLE_W-1:0]        cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [fbh_pkg::SAMPLE_W-1:0]        in_tdata,   // sample[31:0]
  input  wire logic                                in_tlast,   // last_sample
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [fbh_pkg::OUT_DATA_W-1:0]           out_tdata,  // bin_number[5:0], bin_count[29:6]
  output logic                                     out_tlast   // last_bin
);

  fbh_pkg::cmd_t cmd;
  fbh_pkg::sts_t sts;

  fbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbh_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

[verif/fixed_bin_histogram_test.sv]
// testbench for fixed_bin_histogram: directed and random data sets checked against a histogram model
`timescale 1ns / 1ps
module fixed_bin_histogram_test;

  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TOTAL_ITEMS    = 470;

  typedef struct packed {
    logic [fbh_pkg::OUT_NUM_W-1:0] bin_number;
    logic [fbh_pkg::OUT_CNT_W-1:0] bin_count;
    logic                          last_bin;
  } bin_report_t;

  class histogram_scoreboard;
    logic signed [31:0]             range_low;
    logic [30:0]                    bin_width;
    logic [6:0]                     bins_in_use;
    logic [fbh_pkg::COUNT_BITS-1:0] counts [fbh_pkg::NUM_BINS];
    bin_report_t                    bin_reports_due [$];
    int                             bad_fields;

    function new();
      range_low   = 0;
      bin_width   = 31'd65536;
      bins_in_use = 7'd64;
      bad_fields  = 0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function void write_reg(logic [fbh_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] value);
      case (addr)
        fbh_pkg::REG_RANGE_LOW:   range_low   = value;
        fbh_pkg::REG_BIN_WIDTH:   bin_width   = value[30:0];
        fbh_pkg::REG_BINS_IN_USE: bins_in_use = value[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned bins_active();
      int unsigned n;
      n = bins_in_use;
      if (n < 1) n = 1;
      if (n > fbh_pkg::NUM_BINS) n = fbh_pkg::NUM_BINS;
      return n;
    endfunction

    // count one accepted sample; a last sample queues the readout and clears the store
    function void note_sample(logic [31:0] sample, logic last);
      longint      diff;
      longint      quot;
      int unsigned n;
      int unsigned b;
      bin_report_t rep;
      n    = bins_active();
      diff = longint'($signed(sample)) - longint'(range_low);
      if (diff < 0) begin
        b = 0;
      end else if (bin_width == 0) begin
        b = n - 1;
      end else begin
        quot = diff / longint'(bin_width);
        b    = (quot >= n) ? n - 1 : int'(quot);
      end
      if (counts[b] != fbh_pkg::COUNT_MAX) counts[b] = counts[b] + 1'b1;
      if (!last) return;
      for (int unsigned k = 0; k < n; k++) begin
        rep.bin_number = k[5:0];
        rep.bin_count  = counts[k][fbh_pkg::OUT_CNT_W-1:0];
        rep.last_bin   = (k == n - 1);
        bin_reports_due.push_back(rep);
      end
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function void flag(string what, longint exp_val, longint act_val);
      bad_fields++;
      if (bad_fields <= 10)
        $display("%0t: %s: expected %0h, got %0h", $realtime, what, exp_val, act_val);
    endfunction

    function void check_bin(logic [31:0] tdata, logic tlast);
      bin_report_t exp_rep;
      if (bin_reports_due.size() == 0) begin
        flag("bin report with none due", 0, tdata);
        return;
      end
      exp_rep = bin_reports_due.pop_front();
      if (tdata[5:0] !== exp_rep.bin_number)
        flag("bin_number", exp_rep.bin_number, tdata[5:0]);
      if (tdata[29:6] !== exp_rep.bin_count)
        flag($sformatf("bin_count of bin %0d", exp_rep.bin_number), exp_rep.bin_count,
             tdata[29:6]);
      if (tlast !== exp_rep.last_bin)
        flag($sformatf("last_bin of bin %0d", exp_rep.bin_number), exp_rep.last_bin, tlast);
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [fbh_pkg::CFG_ADDR_W-1:0]   cfg_addr;
  logic [fbh_pkg::SAMPLE_W-1:0]     cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [fbh_pkg::SAMPLE_W-1:0]     in_tdata;   // sample[31:0]
  logic                             in_tlast;   // last_sample
  logic                             out_tvalid;
  logic                             out_tready;
  logic [fbh_pkg::OUT_DATA_W-1:0]   out_tdata;  // bin_number[5:0], bin_count[29:6], zero pad
  logic                             out_tlast;  // last_bin

  histogram_scoreboard hist = new();
  int                  items_sent   = 0;
  int                  sender_rush  = 0;
  int                  quiet_cycles = 0;

  fixed_bin_histogram dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls with bursts of constant ready
  initial begin
    int gap;
    int rush;
    rush       = 0;
    out_tready = 1'b0;
    forever begin
      if (rush > 0) begin
        rush--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0) rush = $urandom_range(8, 60);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      hist.check_bin(out_tdata, out_tlast);
    end
  end

  // returns at the accepting edge with valid still high
  task automatic send_item(logic [31:0] sample, logic last);
    int gap;
    if (sender_rush > 0) begin
      sender_rush--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) sender_rush = $urandom_range(8, 40);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = sample;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    hist.note_sample(sample, last);
    items_sent++;
  endtask

  task automatic drop_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (hist.bin_reports_due.size() != 0) @(posedge clk);
  endtask

  // block idle: all reports out and no sample left in the divider
  task automatic settle();
    drop_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [fbh_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    hist.write_reg(addr, value);
  endtask

  task automatic configure(logic [31:0] low, logic [31:0] width, logic [31:0] nbins);
    write_reg(fbh_pkg::REG_RANGE_LOW, low);
    write_reg(fbh_pkg::REG_BIN_WIDTH, width);
    write_reg(fbh_pkg::REG_BINS_IN_USE, nbins);
  endtask

  function automatic logic [31:0] pick_sample(logic [31:0] low, logic [30:0] width,
                                              int unsigned n);
    longint      v;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (width == 0 || mode >= 8) return $urandom();
    if (mode == 7)
      v = longint'($signed(low)) - $urandom_range(1, 1000);
    else if (mode == 6)
      v = longint'($signed(low)) + longint'(width) * n + $urandom_range(0, 1000);
    else
      v = longint'($signed(low)) + longint'(width) * $urandom_range(0, n - 1)
          + $urandom_range(0, width - 1);
    return v[31:0];
  endfunction

  task automatic random_phase();
    logic [31:0] low;
    logic [31:0] width;
    logic [31:0] nbins;
    int unsigned n;
    int unsigned n_sets;
    int unsigned len;
    case ($urandom_range(0, 5))
      0:       low = 32'h8000_0000;
      1:       low = 32'h7FFF_FFFF;
      2:       low = 32'h0000_0000;
      default: low = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0:       width = 32'h0000_0000;
      1:       width = 32'h0000_0001;
      2:       width = 32'h7FFF_FFFF;
      3:       width = 32'h0001_0000;
      default: width = $urandom_range(1, 32'h0010_0000);
    endcase
    // bit 31 lies outside the width register
    if ($urandom_range(0, 3) == 0) width[31] = 1'b1;
    case ($urandom_range(0, 7))
      0:       nbins = 0;
      1:       nbins = 64;
      2:       nbins = 127;
      3:       nbins = $urandom_range(0, 127);
      default: nbins = $urandom_range(1, 16);
    endcase
    settle();
    configure(low, width, nbins);
    n      = hist.bins_active();
    n_sets = $urandom_range(1, 4);
    repeat (n_sets) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if ($urandom_range(0, 5) == 0) begin
        drop_input();
        wait_drained();
      end
      for (int unsigned i = 0; i < len; i++)
        send_item(pick_sample(low, width[30:0], n), i == len - 1);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: range 0, unit bins, all 64 bins
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0003_8000, 1'b0);
    send_item(32'h003F_0000, 1'b0);
    send_item(32'h0001_0000, 1'b1);

    // widest range and widest bins
    settle();
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd4);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);

    // zero bins in use acts as one bin
    settle();
    configure(32'h7FFF_FFFF, 32'h0000_0001, 32'd0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);

    // zero width sends everything to the top bin, oversized bin count is capped
    settle();
    configure(32'h0000_0000, 32'h0000_0000, 32'd127);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b1);

    // bin count shrinks in the middle of a data set
    settle();
    configure(32'hFFFF_0000, 32'h0000_8000, 32'd8);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0001_0000, 1'b0);
    settle();
    write_reg(fbh_pkg::REG_BINS_IN_USE, 32'd2);
    send_item(32'hFFFF_0000, 1'b0);
    send_item(32'h0010_0000, 1'b1);

    while (items_sent < TOTAL_ITEMS) random_phase();

    settle();
    if (hist.bad_fields == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
